### sv/ctc_pkg.sv
`default_nettype none

package ctc_pkg;

  // Number of colours, and the widths of one house cost and one path sum
  localparam int unsigned NCOL    = 3;
  localparam int unsigned COST_W  = 10;
  localparam int unsigned PATH_W  = 21;

  typedef logic [COST_W-1:0] cost_t;
  typedef logic [PATH_W-1:0] path_t;

  // All ones marks a path that cannot be reached; reachable sums stop one below
  localparam path_t UNREACH = {PATH_W{1'b1}};
  localparam path_t SAT_MAX = {{(PATH_W-1){1'b1}}, 1'b0};

  function automatic path_t min2(input path_t a, input path_t b);
    return (a < b) ? a : b;
  endfunction

endpackage

`default_nettype wire

### sv/ctc_row.sv
`default_nettype none

// One row of the min-plus update: all paths that share one first colour.
// Each colour takes the cheaper of the other two colours, adds its own cost
// and saturates; an unreachable predecessor pair stays unreachable.
module ctc_row (
  input  wire ctc_pkg::path_t row_i  [ctc_pkg::NCOL],
  input  wire ctc_pkg::cost_t cost_i [ctc_pkg::NCOL],
  output      ctc_pkg::path_t next_o [ctc_pkg::NCOL]
);
  import ctc_pkg::*;

  path_t              pred [NCOL];
  logic [PATH_W:0]    sum  [NCOL];

  // best predecessor for each colour
  assign pred[0] = min2(row_i[1], row_i[2]);
  assign pred[1] = min2(row_i[0], row_i[2]);
  assign pred[2] = min2(row_i[0], row_i[1]);

  // add and saturate
  always_comb begin
    for (int c = 0; c < NCOL; c++) begin
      sum[c] = {1'b0, pred[c]} + {{(PATH_W+1-COST_W){1'b0}}, cost_i[c]};
      if (pred[c] == UNREACH) begin
        next_o[c] = UNREACH;
      end else if (sum[c] > {1'b0, SAT_MAX}) begin
        next_o[c] = SAT_MAX;
      end else begin
        next_o[c] = sum[c][PATH_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

### sv/cyclic_three_color_min_cost.sv
`default_nettype none

// Channel | Direction | Handshake              | Payload
// --------+-----------+------------------------+----------------------------------------
// in      | input     | in_valid_i / in_stall_o | cost_red_i, cost_green_i, cost_blue_i,
//         |           |                        | last_house_i
// out     | output    | out_valid_o/out_stall_i | min_total_o, valid_res_o
//
// One house request is taken every cycle unless the input stage holds a last
// house facing a stalled result. A request is held in an input register, then
// the nine path sums update; on the last house the ring result moves from the
// input register into the output register once the result side is free. Reset
// clears the path sums to unreachable and arms the first-house flag. A stalled
// result only holds the input stage when that stage carries a last house.
module cyclic_three_color_min_cost (
  input  wire  logic           clk_i,
  input  wire  logic           rst_ni,
  input  wire  logic           in_valid_i,
  output       logic           in_stall_o,
  input  wire  ctc_pkg::cost_t cost_red_i,
  input  wire  ctc_pkg::cost_t cost_green_i,
  input  wire  ctc_pkg::cost_t cost_blue_i,
  input  wire  logic           last_house_i,
  output       logic           out_valid_o,
  input  wire  logic           out_stall_i,
  output       ctc_pkg::path_t min_total_o,
  output       logic           valid_res_o
);
  import ctc_pkg::*;

  // input register
  logic   in_v_q, in_v_d;
  cost_t  cost_q [NCOL];
  logic   last_q;

  // ring state
  path_t  path_q [NCOL][NCOL];
  path_t  path_next [NCOL][NCOL];
  logic   ring_start_q;

  // output register
  logic   out_v_q, out_v_d;
  path_t  min_total_q;
  logic   valid_res_q;

  logic   in_acc, adv, emit;
  path_t  best;

  // the stage moves on unless it holds a last house facing a stalled result
  assign adv        = in_v_q & (~last_q | ~out_v_q | ~out_stall_i);
  assign emit       = adv & last_q;
  assign in_stall_o = in_v_q & ~adv;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign in_v_d     = in_acc | (in_v_q & ~adv);
  assign out_v_d    = emit | (out_v_q & out_stall_i);

  // nine add-min updates, one row per first colour
  for (genvar s = 0; s < NCOL; s++) begin : g_row
    ctc_row u_row (
      .row_i  (path_q[s]),
      .cost_i (cost_q),
      .next_o (path_next[s])
    );
  end

  // least updated sum whose last colour differs from the first
  always_comb begin
    best = UNREACH;
    for (int s = 0; s < NCOL; s++) begin
      for (int c = 0; c < NCOL; c++) begin
        if (c != s) begin
          best = min2(best, path_next[s][c]);
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q       <= 1'b0;
      out_v_q      <= 1'b0;
      ring_start_q <= 1'b1;
    end else begin
      in_v_q  <= in_v_d;
      out_v_q <= out_v_d;
      if (adv) begin
        ring_start_q <= last_q;
      end
    end
  end

  // path sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NCOL; s++) begin
        for (int c = 0; c < NCOL; c++) begin
          path_q[s][c] <= UNREACH;
        end
      end
    end else if (adv) begin
      for (int s = 0; s < NCOL; s++) begin
        for (int c = 0; c < NCOL; c++) begin
          if (last_q) begin
            path_q[s][c] <= UNREACH;
          end else if (ring_start_q) begin
            path_q[s][c] <= (s == c) ? {{(PATH_W-COST_W){1'b0}}, cost_q[c]} : UNREACH;
          end else begin
            path_q[s][c] <= path_next[s][c];
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cost_q[0] <= cost_red_i;
      cost_q[1] <= cost_green_i;
      cost_q[2] <= cost_blue_i;
      last_q    <= last_house_i;
    end
    if (emit) begin
      if (ring_start_q || best == UNREACH) begin
        min_total_q <= '0;
        valid_res_q <= 1'b0;
      end else begin
        min_total_q <= best;
        valid_res_q <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign min_total_o = min_total_q;
  assign valid_res_o = valid_res_q;

  // checks
  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !valid_res_q) |-> (min_total_q == '0))
    else $error("invalid result carries a nonzero total");

  a_valid_reach : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && valid_res_q) |-> (min_total_q <= SAT_MAX))
    else $error("valid result carries the unreachable code");

  a_ring_rearm : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> ring_start_q)
    else $error("ring not rearmed after last house");

  a_stall_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_v_q && last_q && out_v_q && out_stall_i))
    else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

### tb/testbench.sv
`default_nettype none

module testbench;
  import ctc_pkg::*;

  // One ring result as the output channel presents it
  typedef struct {
    path_t total;
    logic  ok;
  } ring_result_t;

  // Tracks the nine path sums and queues the ring results they lead to
  class ring_scoreboard;
    path_t        paths [NCOL][NCOL];
    bit           first_house;
    ring_result_t awaited [$];
    int unsigned  failures;

    function new();
      failures = 0;
      restart();
    endfunction

    function void restart();
      for (int s = 0; s < NCOL; s++) begin
        for (int c = 0; c < NCOL; c++) begin
          paths[s][c] = UNREACH;
        end
      end
      first_house = 1'b1;
    endfunction

    // Unreachable stays unreachable; reachable sums stop at SAT_MAX
    function path_t add_capped(path_t lo, cost_t cst);
      logic [PATH_W:0] sum;
      if (lo == UNREACH) return UNREACH;
      sum = {1'b0, lo} + {{(PATH_W+1-COST_W){1'b0}}, cst};
      return (sum > {1'b0, SAT_MAX}) ? SAT_MAX : sum[PATH_W-1:0];
    endfunction

    // Called for every accepted house request
    function void note_house(cost_t red, cost_t green, cost_t blue, logic last);
      cost_t        cst [NCOL];
      path_t        nxt [NCOL][NCOL];
      path_t        a, b, best;
      ring_result_t res;
      cst[0] = red;
      cst[1] = green;
      cst[2] = blue;
      // first house: a lone house gives no legal colouring
      if (first_house) begin
        if (last) begin
          res.total = '0;
          res.ok    = 1'b0;
          awaited.push_back(res);
          restart();
          return;
        end
        for (int s = 0; s < NCOL; s++) begin
          for (int c = 0; c < NCOL; c++) begin
            paths[s][c] = (s == c) ? path_t'(cst[c]) : UNREACH;
          end
        end
        first_house = 1'b0;
        return;
      end
      // min-plus step for each starting colour
      for (int s = 0; s < NCOL; s++) begin
        for (int c = 0; c < NCOL; c++) begin
          a = paths[s][(c + 1) % NCOL];
          b = paths[s][(c + 2) % NCOL];
          nxt[s][c] = add_capped((a < b) ? a : b, cst[c]);
        end
      end
      paths = nxt;
      // closing the ring: last colour must differ from the first
      if (last) begin
        best = UNREACH;
        for (int s = 0; s < NCOL; s++) begin
          for (int c = 0; c < NCOL; c++) begin
            if (c != s && paths[s][c] < best) best = paths[s][c];
          end
        end
        res.total = (best == UNREACH) ? path_t'(0) : best;
        res.ok    = (best != UNREACH);
        awaited.push_back(res);
        restart();
      end
    endfunction

    // Called for every accepted ring result
    function void check_result(path_t total, logic ok);
      ring_result_t want;
      if (awaited.size() == 0) begin
        $error("unexpected ring result: min_total %0d valid_res %0b", total, ok);
        failures++;
        return;
      end
      want = awaited.pop_front();
      if (total !== want.total) begin
        $error("min_total: expected %0d, got %0d", want.total, total);
        failures++;
      end
      if (ok !== want.ok) begin
        $error("valid_res: expected %0b, got %0b", want.ok, ok);
        failures++;
      end
    endfunction
  endclass

  localparam int unsigned QUIET_LIMIT = 5000;

  logic  clk_i        = 1'b0;
  logic  rst_ni       = 1'b0;
  logic  in_valid_i   = 1'b0;
  logic  in_stall_o;
  cost_t cost_red_i   = '0;
  cost_t cost_green_i = '0;
  cost_t cost_blue_i  = '0;
  logic  last_house_i = 1'b0;
  logic  out_valid_o;
  logic  out_stall_i  = 1'b0;
  path_t min_total_o;
  logic  valid_res_o;

  ring_scoreboard sb = new();

  int unsigned idle_pct   = 0;
  int unsigned stall_pct  = 0;
  int unsigned hold_req   = 0;
  int unsigned hold_left  = 0;
  int unsigned quiet_cnt  = 0;

  cyclic_three_color_min_cost uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cost_red_i   (cost_red_i),
    .cost_green_i (cost_green_i),
    .cost_blue_i  (cost_blue_i),
    .last_house_i (last_house_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .min_total_o  (min_total_o),
    .valid_res_o  (valid_res_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Result side: check accepted results, then pick next cycle's stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(min_total_o, valid_res_o);
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_req != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_req;
      hold_req     = 0;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: too long without any handshake ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  // Offer one house, wait for it to be taken, then maybe go idle
  task automatic offer_house(input cost_t red, input cost_t green, input cost_t blue,
                             input logic last);
    in_valid_i   <= 1'b1;
    cost_red_i   <= red;
    cost_green_i <= green;
    cost_blue_i  <= blue;
    last_house_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_house(red, green, blue, last);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // Costs lean towards the extremes now and then
  function automatic cost_t pick_cost();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return cost_t'($urandom_range(1023));
  endfunction

  task automatic send_ring(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      offer_house(pick_cost(), pick_cost(), pick_cost(), i == len - 1);
    end
  endtask

  // Stop offering until every awaited result is back
  task automatic drain();
    if (in_valid_i) in_valid_i <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_phase(input int unsigned ip, input int unsigned sp,
                           input int unsigned count);
    int unsigned n, r, len;
    idle_pct  = ip;
    stall_pct = sp;
    n = 0;
    while (n < count) begin
      r = $urandom_range(99);
      if (r < 5)       len = 1;
      else if (r < 75) len = $urandom_range(6, 2);
      else if (r < 95) len = $urandom_range(20, 7);
      else             len = $urandom_range(60, 21);
      send_ring(len);
      n += len;
    end
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: lone houses, extremes, forced colour changes, bit patterns
    offer_house(10'd5, 10'd6, 10'd7, 1'b1);
    offer_house('0, '0, '0, 1'b1);
    offer_house('1, '1, '1, 1'b0);
    offer_house('1, '1, '1, 1'b1);
    offer_house('0, '0, '0, 1'b0);
    offer_house('0, '0, '0, 1'b1);
    offer_house(10'd1, '1, '1, 1'b0);
    offer_house('1, 10'd1, '1, 1'b0);
    offer_house('1, '1, 10'd1, 1'b1);
    offer_house('0, '1, '1, 1'b0);
    offer_house('0, '1, '1, 1'b1);
    offer_house(10'h2AA, 10'h155, 10'h3FF, 1'b0);
    offer_house(10'h155, 10'h2AA, 10'h000, 1'b0);
    offer_house(10'h3FF, 10'h000, 10'h2AA, 1'b0);
    offer_house(10'h000, 10'h3FF, 10'h155, 1'b1);
    drain();

    // Free-running phase
    run_phase(0, 0, 140);

    run_phase(78, 0, 140);
    run_phase(0, 78, 140);
    run_phase(37, 37, 140);

    // Long result hold-off while short rings keep coming, so the input backs up
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 400;
    for (int unsigned i = 0; i < 30; i++) send_ring(2);
    drain();

    repeat (8) @(posedge clk_i);
    if (sb.failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
